@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/core/ttse_pkg.sv @@
package ttse_pkg;

  // Default sizes of the token store and of one token walk
  localparam int TABLE_BYTES_DEF = 4096;
  localparam int TOKEN_MAX_DEF   = 32;

  // Input word kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STREAM = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [11:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       symbol_end;
    logic       last;
  } out_word_t;

endpackage

@@ rtl/core/token_table_symbol_expander.sv @@
// Token table symbol expander.
// Input channel item_valid / item_stall / item carries load words and stream
// bytes; output channel res_valid / res_stall / res carries decoded words.
// Load words (token byte, token start offset) give no result. A count byte
// opening a record sets the count of tokens; a zero count gives a single end
// marker. A token byte inside a record walks at most TOKEN_MAX characters:
// it is taken and its start offset read, then the first byte is read, then
// one character at a time comes from the single read port of the token
// store until the closing zero byte is seen, then the token is closed; a
// token cut at TOKEN_MAX has no closing zero.
// The walk is paced by that read port, so one word is worked on at a time.
// A character is held back until the next one is read; the last result of
// a word is held back until the walk ends so that it can be marked.
// Reset clears the record state, holds item_stall high and empties the output
// register; the stores are undefined until loaded and must be written first.
// While res_stall is high the output word is held and the walk pauses on the
// next character that needs to leave; item_stall rises until it is taken.
module token_table_symbol_expander
  import ttse_pkg::*;
#(
  parameter int TABLE_BYTES = TABLE_BYTES_DEF,
  parameter int TOKEN_MAX   = TOKEN_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_word_t  item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res
);

  localparam int AW = $clog2(TABLE_BYTES);
  localparam int CW = $clog2(TOKEN_MAX);

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  // Stores
  logic [7:0]  token_bytes  [TABLE_BYTES];
  logic [11:0] token_starts [256];
  logic [7:0]  byte_q;
  logic [11:0] start_q;

  logic [1:0] state, state_next;
  addr_t      pos, pos_next, rd_pos;
  cnt_t       cnt, cnt_next;
  logic [7:0] tokens_left, tokens_left_next, left_dec;
  logic       in_record, in_record_next;
  logic       first_dropped, first_dropped_next;
  logic       pend_valid, pend_valid_next;
  logic [7:0] pend_ch, pend_ch_next;
  logic       step, sym_end;
  logic       tbl_we, start_we;
  logic       item_accept, out_ready;
  logic       emit;
  out_word_t  emit_word;

  // Fold a 12-bit address into the store with constant compare and subtract
  function automatic addr_t table_index(logic [11:0] v);
    int r;
    r = int'(v);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (TABLE_BYTES << k)) begin
        r = r - (TABLE_BYTES << k);
      end
    end
    return addr_t'(r);
  endfunction

  assign out_ready   = !res_valid || !res_stall;
  assign item_stall  = rst || (state != S_IDLE) || !out_ready;
  assign item_accept = item_valid && !item_stall;
  assign left_dec    = tokens_left - 8'd1;
  assign sym_end     = (left_dec == 8'd0);

  // Decide the next step of the walk
  always_comb begin
    state_next         = state;
    pos_next           = pos;
    cnt_next           = cnt;
    tokens_left_next   = tokens_left;
    in_record_next     = in_record;
    first_dropped_next = first_dropped;
    pend_valid_next    = pend_valid;
    pend_ch_next       = pend_ch;
    rd_pos             = pos;
    tbl_we             = 1'b0;
    start_we           = 1'b0;
    emit               = 1'b0;
    emit_word          = '0;
    step               = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_accept) begin
          unique case (item.kind)
            KIND_BYTE:  tbl_we = 1'b1;
            KIND_START: start_we = 1'b1;
            KIND_STREAM: begin
              if (!in_record) begin
                if (item.value[7:0] == 8'd0) begin
                  emit                 = 1'b1;
                  emit_word.symbol_end = 1'b1;
                  emit_word.last       = 1'b1;
                end else begin
                  tokens_left_next   = item.value[7:0];
                  in_record_next     = 1'b1;
                  first_dropped_next = 1'b0;
                end
              end else begin
                cnt_next        = '0;
                pend_valid_next = 1'b0;
                state_next      = S_START;
              end
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        rd_pos     = table_index(start_q);
        pos_next   = rd_pos;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (byte_q == 8'd0) begin
          state_next = S_FLUSH;
        end else if (!first_dropped) begin
          first_dropped_next = 1'b1;
          step               = 1'b1;
        end else if (!pend_valid || out_ready) begin
          // Release the held character, keep the new one back
          emit               = pend_valid;
          emit_word.ch       = pend_ch;
          emit_word.has_char = 1'b1;
          pend_ch_next       = byte_q;
          pend_valid_next    = 1'b1;
          step               = 1'b1;
        end
        if (step) begin
          rd_pos   = (pos == addr_t'(TABLE_BYTES - 1)) ? '0 : addr_t'(pos + 1'b1);
          pos_next = rd_pos;
          cnt_next = cnt_t'(cnt + 1'b1);
          if (cnt == cnt_t'(TOKEN_MAX - 1)) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        // Close the token: last word of the item, end of record if count runs out
        if (!((pend_valid || sym_end) && !out_ready)) begin
          emit                 = pend_valid || sym_end;
          emit_word.ch         = pend_valid ? pend_ch : 8'd0;
          emit_word.has_char   = pend_valid;
          emit_word.symbol_end = sym_end;
          emit_word.last       = 1'b1;
          tokens_left_next     = left_dec;
          pend_valid_next      = 1'b0;
          if (sym_end) begin
            in_record_next     = 1'b0;
            first_dropped_next = 1'b0;
          end
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // Token store: one write port for loads, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      token_bytes[table_index(item.addr)] <= item.value[7:0];
    end
    byte_q <= token_bytes[rd_pos];
  end

  // Start offset table
  always_ff @(posedge clk) begin
    if (start_we) begin
      token_starts[item.addr[7:0]] <= item.value;
    end
    start_q <= token_starts[item.value[7:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tokens_left   <= '0;
      in_record     <= 1'b0;
      first_dropped <= 1'b0;
      pend_valid    <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      tokens_left   <= tokens_left_next;
      in_record     <= in_record_next;
      first_dropped <= first_dropped_next;
      pend_valid    <= pend_valid_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    cnt     <= cnt_next;
    pend_ch <= pend_ch_next;
    if (emit) begin
      res <= emit_word;
    end
  end

endmodule

@@ rtl/core/ttse_checker.sv @@
`include "assert_macros.svh"

module ttse_checker
  import ttse_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_stall,
  input in_word_t  item,
  input logic      res_valid,
  input logic      res_stall,
  input out_word_t res
);

  // Hold a stalled output word
  `ASSERT_CLK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "output word changed under stall")

  // A bare marker always closes the record and the item
  `ASSERT_CLK(a_marker_ends, res_valid && !res.has_char |-> res.symbol_end && res.last, "bare marker not at record end")

  // End of record is always the last word of its item
  `ASSERT_NEVER(a_end_is_last, res_valid && res.symbol_end && !res.last, "record end without last")

  // A bare marker carries no character
  `ASSERT_NEVER(a_marker_clean, res_valid && !res.has_char && res.ch != 8'd0, "marker with character bits")

endmodule

bind token_table_symbol_expander ttse_checker u_ttse_checker (.*);

@@ sim/token_table_symbol_expander_tb.sv @@
module token_table_symbol_expander_tb;
  import ttse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Kind code that the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Quiet cycles after the last word: one full token walk plus pipeline
  localparam int SETTLE_CYCLES = TOKEN_MAX_DEF + 16;
  localparam int RANDOM_WORDS = 110;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_word_t item;
  logic res_valid;
  logic res_stall;
  out_word_t res;

  // Dictionary copy and record state of the expander
  logic [7:0] dict_bytes [TABLE_BYTES_DEF];
  bit byte_known [TABLE_BYTES_DEF];
  logic [11:0] dict_starts [256];
  bit start_known [256];
  logic [7:0] tokens_left;
  bit in_record;
  bit first_gone;

  out_word_t pending_chars [$];
  out_word_t want;
  int mismatches;
  int words_sent;
  bit tx_gaps_on;
  bit rx_gaps_on;
  int rx_hold_left;

  token_table_symbol_expander DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Expand one accepted word into the characters it should produce
  function automatic void expand_word(in_word_t w);
    out_word_t walk [$];
    out_word_t marker;
    int pos;
    logic [7:0] c;
    marker = '{ch: 8'h00, has_char: 1'b0, symbol_end: 1'b1, last: 1'b1};
    case (w.kind)
      KIND_BYTE: begin
        dict_bytes[w.addr % TABLE_BYTES_DEF] = w.value[7:0];
        byte_known[w.addr % TABLE_BYTES_DEF] = 1'b1;
      end
      KIND_START: begin
        dict_starts[w.addr[7:0]] = w.value;
        start_known[w.addr[7:0]] = 1'b1;
      end
      KIND_STREAM: begin
        if (!in_record) begin
          // Count byte: zero closes at once with a bare marker
          if (w.value[7:0] == 8'h00) begin
            pending_chars.push_back(marker);
          end else begin
            tokens_left = w.value[7:0];
            in_record = 1'b1;
            first_gone = 1'b0;
          end
        end else begin
          // Walk the token, dropping the first character of the record
          pos = dict_starts[w.value[7:0]] % TABLE_BYTES_DEF;
          for (int i = 0; i < TOKEN_MAX_DEF; i++) begin
            c = dict_bytes[pos];
            if (c == 8'h00) break;
            if (first_gone)
              walk.push_back('{ch: c, has_char: 1'b1, symbol_end: 1'b0, last: 1'b0});
            else
              first_gone = 1'b1;
            pos = (pos + 1) % TABLE_BYTES_DEF;
          end
          tokens_left = tokens_left - 8'd1;
          if (tokens_left == 8'd0) begin
            in_record = 1'b0;
            first_gone = 1'b0;
            if (walk.size() == 0)
              walk.push_back(marker);
            else
              walk[walk.size() - 1].symbol_end = 1'b1;
          end
          if (walk.size() > 0) walk[walk.size() - 1].last = 1'b1;
          foreach (walk[i]) pending_chars.push_back(walk[i]);
        end
      end
      default: ;
    endcase
  endfunction

  // A token may be walked only if every byte it touches has been loaded
  function automatic bit walk_is_safe(logic [7:0] idx);
    int pos;
    if (!start_known[idx]) return 1'b0;
    pos = dict_starts[idx] % TABLE_BYTES_DEF;
    for (int i = 0; i < TOKEN_MAX_DEF; i++) begin
      if (!byte_known[pos]) return 1'b0;
      if (dict_bytes[pos] == 8'h00) return 1'b1;
      pos = (pos + 1) % TABLE_BYTES_DEF;
    end
    return 1'b1;
  endfunction

  function automatic in_word_t make_word(logic [1:0] k, logic [11:0] a, logic [11:0] v);
    return '{kind: k, addr: a, value: v};
  endfunction

  // Offer one word at a falling edge and hold it until taken
  task automatic send_word(in_word_t w);
    while (tx_gaps_on && $urandom_range(99) < 10) @(negedge clk);
    item = w;
    item_valid = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expand_word(w);
    words_sent++;
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  // Load a token of random text at a random offset; long ones may reach or run past TOKEN_MAX
  task automatic load_random_token(output logic [7:0] idx);
    int start;
    int len;
    idx = 8'($urandom_range(255));
    start = $urandom_range(TABLE_BYTES_DEF - 1);
    len = ($urandom_range(9) == 0) ? $urandom_range(TOKEN_MAX_DEF + 8, TOKEN_MAX_DEF - 4)
                                   : $urandom_range(6);
    for (int i = 0; i < len; i++)
      send_word(make_word(KIND_BYTE, 12'((start + i) % TABLE_BYTES_DEF),
                          {4'($urandom), 8'($urandom_range(255, 1))}));
    if (len < TOKEN_MAX_DEF)
      send_word(make_word(KIND_BYTE, 12'((start + len) % TABLE_BYTES_DEF),
                          {4'($urandom), 8'h00}));
    send_word(make_word(KIND_START, {4'($urandom), idx}, 12'(start)));
  endtask

  // Choose a token that is safe to walk, loading a fresh one if none is
  task automatic pick_token(output logic [7:0] idx);
    int base;
    bit found;
    base = $urandom_range(255);
    found = 1'b0;
    for (int i = 0; i < 256 && !found; i++) begin
      idx = 8'(base + i);
      found = walk_is_safe(idx);
    end
    if (!found) load_random_token(idx);
  endtask

  // Send a count byte and that many token selectors
  task automatic send_record(logic [11:0] count_word);
    logic [7:0] idx;
    int pos;
    send_word(make_word(KIND_STREAM, 12'($urandom), count_word));
    for (int t = 0; t < count_word[7:0]; t++) begin
      pick_token(idx);
      // Now and then rewrite the token's first character mid record
      pos = dict_starts[idx] % TABLE_BYTES_DEF;
      if ($urandom_range(7) == 0 && dict_bytes[pos] != 8'h00)
        send_word(make_word(KIND_BYTE, 12'(pos), {4'($urandom), 8'($urandom)}));
      send_word(make_word(KIND_STREAM, 12'($urandom), {4'($urandom), idx}));
    end
  endtask

  // Hand-picked dictionary and records covering the corner cases
  task automatic test_directed_records();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    // Token FF wraps round the end of the store, high value bits set
    send_word(make_word(KIND_BYTE, 12'hFFE, 12'hF58));
    send_word(make_word(KIND_BYTE, 12'hFFF, 12'h059));
    send_word(make_word(KIND_BYTE, 12'h000, 12'h05A));
    send_word(make_word(KIND_BYTE, 12'h001, 12'hF00));
    send_word(make_word(KIND_START, 12'hFFF, 12'hFFE));
    // Token 0 emits nothing
    send_word(make_word(KIND_BYTE, 12'h002, 12'h000));
    send_word(make_word(KIND_START, 12'h000, 12'h002));
    // Token 1 is a single character
    send_word(make_word(KIND_BYTE, 12'h010, 12'h051));
    send_word(make_word(KIND_BYTE, 12'h011, 12'h000));
    send_word(make_word(KIND_START, 12'h301, 12'h010));
    // Ignored kind, then an empty record with high bits set
    send_word(make_word(KIND_UNUSED, 12'hFFF, 12'hFFF));
    send_word(make_word(KIND_STREAM, 12'h000, 12'hF00));
    // Two tokens across the wrap, selector with high bits
    send_word(make_word(KIND_STREAM, 12'hFFF, 12'h002));
    send_word(make_word(KIND_STREAM, 12'h000, 12'h0FF));
    send_word(make_word(KIND_STREAM, 12'h000, 12'hA01));
    // Silent final token
    send_word(make_word(KIND_STREAM, 12'h000, 12'h001));
    send_word(make_word(KIND_STREAM, 12'h000, 12'h000));
    // Silent token in the middle, first character dropped from a lone char
    send_word(make_word(KIND_STREAM, 12'h000, 12'h003));
    send_word(make_word(KIND_STREAM, 12'h000, 12'h001));
    send_word(make_word(KIND_STREAM, 12'h000, 12'h000));
    send_word(make_word(KIND_STREAM, 12'h000, 12'h001));
    // Store write inside a record changes the next walk
    send_word(make_word(KIND_STREAM, 12'h000, 12'h002));
    send_word(make_word(KIND_STREAM, 12'h000, 12'h001));
    send_word(make_word(KIND_BYTE, 12'h010, 12'h052));
    send_word(make_word(KIND_STREAM, 12'h000, 12'h001));
  endtask

  // Mostly well-formed records with random content, plus loads and noise
  task automatic test_random_records();
    int stop_at;
    int roll;
    logic [7:0] idx;
    stop_at = words_sent + RANDOM_WORDS;
    // Open with a stretch where neither side idles
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    while (words_sent < stop_at) begin
      if (words_sent > stop_at - RANDOM_WORDS + 60) begin
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 12)
        load_random_token(idx);
      else if (roll < 17)
        send_word(make_word(KIND_UNUSED, 12'($urandom), 12'($urandom)));
      else if (roll < 22)
        send_record({4'($urandom), 8'h00});
      else
        send_record({4'($urandom), 8'($urandom_range(6, 1))});
    end
  endtask

  // Longest record while the result side holds off, so the input backs up
  task automatic test_full_record_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    rx_hold_left = 400;
    send_record(12'hFFF);
    tx_gaps_on = 1'b1;
  endtask

  // Result side: long hold when asked, otherwise random stalls
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        res_stall = 1'b1;
        rx_hold_left--;
      end else begin
        res_stall = rx_gaps_on && ($urandom_range(99) < 10);
      end
    end
  end

  // Compare each taken word with the oldest expected one
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected word ch %h has_char %b symbol_end %b last %b, expected none",
                 $time, res.ch, res.has_char, res.symbol_end, res.last);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (res !== want) begin
          $display("%0t: ch exp %h act %h, has_char exp %b act %b, symbol_end exp %b act %b, last exp %b act %b",
                   $time, want.ch, res.ch, want.has_char, res.has_char,
                   want.symbol_end, res.symbol_end, want.last, res.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    tokens_left = 8'd0;
    in_record = 1'b0;
    first_gone = 1'b0;
    mismatches = 0;
    words_sent = 0;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    rx_hold_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_records();
    test_random_records();
    test_full_record_backpressure();

    // Drain, then watch for stray words
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ttse_pkg.sv
rtl/core/token_table_symbol_expander.sv
rtl/core/ttse_checker.sv
sim/token_table_symbol_expander_tb.sv
